// File: rtl/core/tiny_register_vm_core_top_defines.svh
// assertion macros for the tiny register vm core
// used by rtl files that carry concurrent checks, no other dependencies
`ifndef TINY_REGISTER_VM_CORE_TOP_DEFINES_SVH
`define TINY_REGISTER_VM_CORE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// File: rtl/core/trvm_pkg.sv
// shared types and constants for the tiny register vm core
// no dependencies
`default_nettype none

package trvm_pkg;

    localparam int WORD_W      = 16;
    localparam int OP_W        = 4;
    localparam int IDX_W       = 4;
    localparam int IMM_W       = 8;
    localparam int NUM_GPR     = 8;
    localparam int GPR_IDX_W   = $clog2(NUM_GPR);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(WORD_W);

    localparam logic [OP_W-1:0] OP_HALT = 4'h0;
    localparam logic [OP_W-1:0] OP_ADD  = 4'h1;
    localparam logic [OP_W-1:0] OP_SUB  = 4'h2;
    localparam logic [OP_W-1:0] OP_DIV  = 4'h3;
    localparam logic [OP_W-1:0] OP_MUL  = 4'h4;
    localparam logic [OP_W-1:0] OP_PRR  = 4'h5;
    localparam logic [OP_W-1:0] OP_PRI  = 4'h6;
    localparam logic [OP_W-1:0] OP_STI  = 4'h7;

    localparam logic [IDX_W-1:0]  IDX_PC       = 4'd8;
    localparam logic [WORD_W-1:0] DIV_ZERO_VAL = 16'hFFFF;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] dest;
        logic [IDX_W-1:0] rd_a;
        logic [IDX_W-1:0] rd_b;
        logic [IMM_W-1:0] imm;
    } t_dec;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
    } t_div_st;

endpackage

`default_nettype wire

// File: rtl/core/trvm_front.sv
// front end: takes instruction words and splits them into decoded fields
// depends on trvm_pkg
`default_nettype none

module trvm_front
    import trvm_pkg::*;
(
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [WORD_W-1:0] i_instruction,
    output logic                   o_push,
    output t_dec                   o_dec,
    input  wire logic              i_q_ready
);

    logic [OP_W-1:0] op;

    assign op = i_instruction[15:12];

    always_comb begin
        o_dec.op   = op;
        o_dec.dest = i_instruction[11:8];
        o_dec.rd_a = (op == OP_PRR) ? i_instruction[11:8] : i_instruction[7:4];
        o_dec.rd_b = i_instruction[3:0];
        o_dec.imm  = i_instruction[7:0];
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

endmodule

`default_nettype wire

// File: rtl/core/trvm_queue.sv
// short queue of decoded words between front and back
// depends on trvm_pkg
`default_nettype none

module trvm_queue
    import trvm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_dec i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_dec      o_data,
    input  wire logic i_pop
);

    t_dec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              push_ok;
    logic              pop_ok;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop_ok) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/trvm_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on trvm_pkg
`default_nettype none

module trvm_div
    import trvm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_st       o_st
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WORD_W-1:0]    r_rem;
    logic [WORD_W-1:0]    r_quo;
    logic [WORD_W-1:0]    r_dvs;
    logic [WORD_W:0]      shifted;
    logic [WORD_W:0]      diff;
    logic                 ge;

    assign shifted = {r_rem, r_quo[WORD_W-1]};
    assign ge      = (shifted >= {1'b0, r_dvs});
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= DIV_CNT_W'(r_cnt + 1'b1);
            if (r_cnt == DIV_CNT_W'(WORD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], ge};
        end
    end

    assign o_st.done = r_done;
    assign o_st.quot = r_quo;

endmodule

`default_nettype wire

// File: rtl/core/trvm_back.sv
// back end: register file, program counter, execute and result register
// depends on trvm_pkg, trvm_div through its ports, and the assertion macros
`default_nettype none
`include "tiny_register_vm_core_top_defines.svh"

module trvm_back
    import trvm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire t_dec               i_q_data,
    output logic                    o_q_pop,
    output t_div_req                o_div_req,
    input  wire t_div_st            i_div_st,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [WORD_W-1:0]       o_next_fetch_address,
    output logic                    o_print_valid,
    output logic [WORD_W-1:0]       o_print_value,
    output logic                    o_halted,
    output logic                    o_divide_by_zero
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [WORD_W-1:0] r_gpr [NUM_GPR];
    logic [NUM_GPR-1:0] r_gpr_vld;
    logic [WORD_W-1:0] r_rd_a;
    logic [WORD_W-1:0] r_rd_b;
    logic              r_rd_a_vld;
    logic              r_rd_b_vld;

    logic [1:0]        r_state, n_state;
    t_dec              r_ins, n_ins;
    logic [WORD_W-1:0] r_pc, n_pc;
    logic              r_halt, n_halt;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_nfa, n_nfa;
    logic              r_pv, n_pv;
    logic [WORD_W-1:0] r_pval, n_pval;
    logic              r_halted, n_halted;
    logic              r_dz, n_dz;

    logic              out_free;
    logic [WORD_W-1:0] pc1;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [2*WORD_W-1:0] prod;
    logic              wr_en;
    logic [WORD_W-1:0] wr_val;

    function automatic logic [WORD_W-1:0] reg_val(
        input logic [IDX_W-1:0]  idx,
        input logic [WORD_W-1:0] data,
        input logic              vld,
        input logic [WORD_W-1:0] pc
    );
        logic [WORD_W-1:0] v;
        if (idx < IDX_W'(NUM_GPR)) begin
            v = vld ? data : '0;
        end else if (idx == IDX_PC) begin
            v = pc;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    assign out_free = !r_out_valid || i_ready;
    assign pc1      = WORD_W'(r_pc + 1'b1);
    assign a        = reg_val(r_ins.rd_a, r_rd_a, r_rd_a_vld, pc1);
    assign b        = reg_val(r_ins.rd_b, r_rd_b, r_rd_b_vld, pc1);
    assign prod     = a * b;

    always_comb begin
        n_state     = r_state;
        n_ins       = r_ins;
        n_pc        = r_pc;
        n_halt      = r_halt;
        n_out_valid = r_out_valid && !i_ready;
        n_nfa       = r_nfa;
        n_pv        = r_pv;
        n_pval      = r_pval;
        n_halted    = r_halted;
        n_dz        = r_dz;
        wr_en       = 1'b0;
        wr_val      = '0;
        o_q_pop     = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = a;
        o_div_req.divisor  = b;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_ins   = i_q_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_pv        = 1'b0;
                    n_pval      = '0;
                    n_dz        = 1'b0;
                    if (r_halt) begin
                        n_nfa    = r_pc;
                        n_halted = 1'b1;
                    end else begin
                        n_halted = 1'b0;
                        n_pc     = pc1;
                        unique case (r_ins.op)
                            OP_HALT: begin
                                n_halt   = 1'b1;
                                n_halted = 1'b1;
                            end
                            OP_ADD: begin
                                wr_en  = 1'b1;
                                wr_val = WORD_W'(a + b);
                            end
                            OP_SUB: begin
                                wr_en  = 1'b1;
                                wr_val = WORD_W'(a - b);
                            end
                            OP_DIV: begin
                                if (b == '0) begin
                                    wr_en  = 1'b1;
                                    wr_val = DIV_ZERO_VAL;
                                    n_dz   = 1'b1;
                                end else begin
                                    o_div_req.start = 1'b1;
                                    n_out_valid     = 1'b0;
                                    n_state         = S_DIV;
                                end
                            end
                            OP_MUL: begin
                                wr_en  = 1'b1;
                                wr_val = prod[WORD_W-1:0];
                            end
                            OP_PRR: begin
                                n_pv   = 1'b1;
                                n_pval = a;
                            end
                            OP_PRI: begin
                                n_pv   = 1'b1;
                                n_pval = {{(WORD_W-IMM_W){1'b0}}, r_ins.imm};
                            end
                            OP_STI: begin
                                wr_en  = 1'b1;
                                wr_val = {{(WORD_W-IMM_W){1'b0}}, r_ins.imm};
                            end
                            default: begin
                            end
                        endcase
                        if (wr_en && (r_ins.dest == IDX_PC)) begin
                            n_pc = wr_val;
                        end
                        n_nfa = n_pc;
                    end
                end
            end
            S_DIV: begin
                if (i_div_st.done && out_free) begin
                    wr_en       = 1'b1;
                    wr_val      = i_div_st.quot;
                    if (r_ins.dest == IDX_PC) begin
                        n_pc = i_div_st.quot;
                    end
                    n_nfa       = n_pc;
                    n_out_valid = 1'b1;
                    n_pv        = 1'b0;
                    n_pval      = '0;
                    n_halted    = 1'b0;
                    n_dz        = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
            r_gpr_vld   <= '0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_halt      <= n_halt;
            r_out_valid <= n_out_valid;
            if (wr_en && (r_ins.dest < IDX_W'(NUM_GPR))) begin
                r_gpr_vld[r_ins.dest[GPR_IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins    <= n_ins;
        r_nfa    <= n_nfa;
        r_pv     <= n_pv;
        r_pval   <= n_pval;
        r_halted <= n_halted;
        r_dz     <= n_dz;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (r_ins.dest < IDX_W'(NUM_GPR))) begin
            r_gpr[r_ins.dest[GPR_IDX_W-1:0]] <= wr_val;
        end
        if (o_q_pop) begin
            r_rd_a     <= r_gpr[i_q_data.rd_a[GPR_IDX_W-1:0]];
            r_rd_b     <= r_gpr[i_q_data.rd_b[GPR_IDX_W-1:0]];
            r_rd_a_vld <= r_gpr_vld[i_q_data.rd_a[GPR_IDX_W-1:0]];
            r_rd_b_vld <= r_gpr_vld[i_q_data.rd_b[GPR_IDX_W-1:0]];
        end
    end

    assign o_valid              = r_out_valid;
    assign o_next_fetch_address = r_nfa;
    assign o_print_valid        = r_pv;
    assign o_print_value        = r_pval;
    assign o_halted             = r_halted;
    assign o_divide_by_zero     = r_dz;

    `ASSERT_CLK(a_halt_sticky, i_clk, i_rst_n, r_halt |=> r_halt)
    `ASSERT_CLK(a_pop_only_idle, i_clk, i_rst_n, o_q_pop |-> (r_state == S_IDLE))
    `ASSERT_CLK(a_div_start_waits, i_clk, i_rst_n, o_div_req.start |=> (r_state == S_DIV))
    `ASSERT_NEVER(a_dz_no_print, i_clk, i_rst_n, o_valid && o_divide_by_zero && o_print_valid)

endmodule

`default_nettype wire

// File: rtl/core/tiny_register_vm_core_top.sv
// top level of the tiny register vm core: front, queue, back and divider
// depends on trvm_pkg, trvm_front, trvm_queue, trvm_div, trvm_back
//
// input channel: one 16-bit instruction word per handshake (i_valid / o_ready),
// fetched from program memory outside the block at the last next fetch address.
// output channel: one result word per instruction (o_valid / i_ready) with the
// next fetch address, print flag and value, halted flag and divide-by-zero flag.
// a two-entry queue sits between the decoding front and the executing back.
// path: an accepted word waits in the queue, is popped in the idle state with
// a registered read of the register file, runs in the execute state and is
// then held in the result register; a divide with a nonzero divisor also waits
// in the divide state for the bit-serial divider, one quotient bit per cycle.
// the back takes a new word only after the last has left execute or divide.
// reset: registers, program counter and halt flag clear, queue and result
// register empty; after a halt each word gives the held counter and halted.
// receiver stall: the result register holds, the back stops, and the queue
// fills, after which o_ready drops until results are taken.
`default_nettype none

module tiny_register_vm_core_top
    import trvm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [WORD_W-1:0] i_instruction,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [WORD_W-1:0]      o_next_fetch_address,
    output logic                   o_print_valid,
    output logic [WORD_W-1:0]      o_print_value,
    output logic                   o_halted,
    output logic                   o_divide_by_zero
);

    logic     push;
    t_dec     f_dec;
    logic     q_ready;
    logic     q_valid;
    t_dec     q_data;
    logic     q_pop;
    t_div_req div_req;
    t_div_st  div_st;

    trvm_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_instruction (i_instruction),
        .o_push        (push),
        .o_dec         (f_dec),
        .i_q_ready     (q_ready)
    );

    trvm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_dec),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    trvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_st    (div_st)
    );

    trvm_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_valid            (q_valid),
        .i_q_data             (q_data),
        .o_q_pop              (q_pop),
        .o_div_req            (div_req),
        .i_div_st             (div_st),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_next_fetch_address (o_next_fetch_address),
        .o_print_valid        (o_print_valid),
        .o_print_value        (o_print_value),
        .o_halted             (o_halted),
        .o_divide_by_zero     (o_divide_by_zero)
    );

endmodule

`default_nettype wire
